// ===== src/slk_pkg.sv =====
package slk_pkg;

	localparam int NUM_KEYS_DEF = 3;
	localparam int WORD_W       = 32;
	localparam int IDX_W        = 2;
	localparam int CNT_W        = 8;
	localparam int NUM_REGS     = 3;

	// register indexes on the config port
	localparam logic [IDX_W-1:0] REG_SECURITY_0 = 2'd0;
	localparam logic [IDX_W-1:0] REG_SECURITY_1 = 2'd1;
	localparam logic [IDX_W-1:0] REG_SECURITY_2 = 2'd2;

	localparam logic [7:0] MASK_XOR  = 8'hA5;
	localparam logic [7:0] ADD_XOR   = 8'h5A;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SHIFT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load_seed;  // take a new seed, restart at key 0
		logic load_key;   // load shift register and pass count for current key
		logic shift;      // one shift register pass
		logic capture;    // finish current key into the output register
		logic next_key;   // advance to the next security constant
	} cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic last_key;
	} status_t;

endpackage

// ===== src/slk_ctrl.sv =====
module slk_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             seed_valid,
	output logic             seed_ready,
	output logic             key_valid,
	input  logic             key_ready,
	input  slk_pkg::status_t status,
	output slk_pkg::cmd_t    cmd
);

	slk_pkg::state_t state_q;
	slk_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slk_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			slk_pkg::ST_IDLE: begin
				if (seed_valid) begin
					state_d = slk_pkg::ST_LOAD;
				end
			end
			slk_pkg::ST_LOAD: begin
				state_d = slk_pkg::ST_SHIFT;
			end
			slk_pkg::ST_SHIFT: begin
				if (status.cnt_zero) begin
					state_d = slk_pkg::ST_EMIT;
				end
			end
			slk_pkg::ST_EMIT: begin
				if (key_ready) begin
					state_d = status.last_key ? slk_pkg::ST_IDLE : slk_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = slk_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd        = '0;
		seed_ready = 1'b0;
		key_valid  = 1'b0;
		unique case (state_q)
			slk_pkg::ST_IDLE: begin
				seed_ready    = 1'b1;
				cmd.load_seed = seed_valid;
			end
			slk_pkg::ST_LOAD: begin
				cmd.load_key = 1'b1;
			end
			slk_pkg::ST_SHIFT: begin
				cmd.shift   = !status.cnt_zero;
				cmd.capture = status.cnt_zero;
			end
			slk_pkg::ST_EMIT: begin
				key_valid    = 1'b1;
				cmd.next_key = key_ready && !status.last_key;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

`ifndef SYNTHESIS
	// a word is never offered while a seed can be taken
	a_ready_valid_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(seed_ready && key_valid))
		else $error("seed_ready and key_valid both high");

	// after a seed is taken the next key setup follows immediately
	a_seed_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_seed |=> cmd.load_key)
		else $error("load did not follow seed acceptance");

	// an offered word stays offered until taken
	a_key_held: assert property (@(posedge clk) disable iff (!arst_n)
		key_valid && !key_ready |=> key_valid)
		else $error("key_valid dropped before the word was taken");
`endif

endmodule

// ===== src/slk_dp.sv =====
module slk_dp #(
	parameter int NUM_KEYS = slk_pkg::NUM_KEYS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [slk_pkg::IDX_W-1:0]     cfg_index,
	input  logic [slk_pkg::WORD_W-1:0]    cfg_wdata,
	input  logic [slk_pkg::WORD_W-1:0]    seed,
	input  slk_pkg::cmd_t                 cmd,
	output slk_pkg::status_t              status,
	output logic [slk_pkg::WORD_W-1:0]    key,
	output logic [slk_pkg::IDX_W-1:0]     key_index,
	output logic                          last
);

	localparam logic [slk_pkg::IDX_W-1:0] LAST_IDX = slk_pkg::IDX_W'(NUM_KEYS - 1);

	logic [slk_pkg::WORD_W-1:0] sec_q [slk_pkg::NUM_REGS];
	logic [slk_pkg::WORD_W-1:0] seed_q;
	logic [slk_pkg::WORD_W-1:0] shift_q;
	logic [slk_pkg::CNT_W-1:0]  cnt_q;
	logic [slk_pkg::IDX_W-1:0]  idx_q;
	logic [slk_pkg::WORD_W-1:0] key_q;
	logic [slk_pkg::IDX_W-1:0]  key_index_q;
	logic                       last_q;

	logic [slk_pkg::WORD_W-1:0] sec;
	logic [7:0]                 sel_byte;
	logic [slk_pkg::CNT_W-1:0]  pass_cnt;
	logic [slk_pkg::WORD_W-1:0] shift_next;
	logic [slk_pkg::WORD_W-1:0] swapped;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q[0] <= '0;
			sec_q[1] <= '0;
			sec_q[2] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				slk_pkg::REG_SECURITY_0: sec_q[0] <= cfg_wdata;
				slk_pkg::REG_SECURITY_1: sec_q[1] <= cfg_wdata;
				slk_pkg::REG_SECURITY_2: sec_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx_q)
			slk_pkg::REG_SECURITY_0: sec = sec_q[0];
			slk_pkg::REG_SECURITY_1: sec = sec_q[1];
			default:                 sec = sec_q[2];
		endcase
	end

	// byte select: {bit11, bit21}
	always_comb begin
		case ({sec[11], sec[21]})
			2'd0:    sel_byte = seed_q[31:24];
			2'd1:    sel_byte = seed_q[23:16];
			2'd2:    sel_byte = seed_q[15:8];
			default: sel_byte = seed_q[7:0];
		endcase
	end

	assign pass_cnt = ((sel_byte ^ sec[9:2]) & (sec[30:23] ^ slk_pkg::MASK_XOR))
		+ (sec[20:13] ^ slk_pkg::ADD_XOR);

	assign shift_next = {shift_q[30:0], shift_q[30] ^ shift_q[24] ^ shift_q[12] ^ shift_q[2]};

	assign swapped = sec[0] ? {shift_q[15:8], shift_q[31:24], shift_q[7:0], shift_q[23:16]}
		: shift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load_seed) begin
			idx_q <= '0;
		end else if (cmd.next_key) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_seed) begin
			seed_q <= seed;
		end
		if (cmd.load_key) begin
			shift_q <= seed_q;
			cnt_q   <= pass_cnt;
		end else if (cmd.shift) begin
			shift_q <= shift_next;
			cnt_q   <= cnt_q - 1'b1;
		end
		if (cmd.capture) begin
			key_q       <= swapped ^ sec;
			key_index_q <= idx_q;
			last_q      <= (idx_q == LAST_IDX);
		end
	end

	assign status.cnt_zero = (cnt_q == '0);
	assign status.last_key = (idx_q == LAST_IDX);

	assign key       = key_q;
	assign key_index = key_index_q;
	assign last      = last_q;

`ifndef SYNTHESIS
	a_shift_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |-> cnt_q != '0)
		else $error("shift issued with zero pass count");

	a_capture_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> cnt_q == '0)
		else $error("key captured before all passes done");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= LAST_IDX)
		else $error("key index beyond last constant");
`endif

endmodule

// ===== src/seed_key_lfsr_calculator_top.sv =====
// Seed-to-key calculator.
// Input channel: seed_valid/seed_ready with a 32-bit seed word. Output channel:
// key_valid/key_ready with key, key_index and last; each seed yields NUM_KEYS
// words, key_index counting 0 up, last set on the final one.
// Config port: cfg_we/cfg_index/cfg_wdata writes security_0..2 (index 0..2);
// index 3 is ignored. Write only while no seed is in flight.
// Flow: one seed at a time. Per key: a setup step that loads the shift register,
// then n shift register passes (n is the pass count, 0..255, one pass per cycle),
// then a finishing step that captures the word, which then waits in the output
// register until taken. seed_ready is high only when idle.
// Reset clears the security registers to zero and returns to idle with no word
// pending. A stalled receiver simply holds the block in its output state with
// the word steady; nothing is lost.
module seed_key_lfsr_calculator_top #(
	parameter int NUM_KEYS = slk_pkg::NUM_KEYS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [slk_pkg::IDX_W-1:0]  cfg_index,
	input  logic [slk_pkg::WORD_W-1:0] cfg_wdata,
	input  logic                       seed_valid,
	output logic                       seed_ready,
	input  logic [slk_pkg::WORD_W-1:0] seed,
	output logic                       key_valid,
	input  logic                       key_ready,
	output logic [slk_pkg::WORD_W-1:0] key,
	output logic [slk_pkg::IDX_W-1:0]  key_index,
	output logic                       last
);

	slk_pkg::cmd_t    cmd;
	slk_pkg::status_t status;

	slk_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed_valid (seed_valid),
		.seed_ready (seed_ready),
		.key_valid  (key_valid),
		.key_ready  (key_ready),
		.status     (status),
		.cmd        (cmd)
	);

	slk_dp #(
		.NUM_KEYS (NUM_KEYS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.seed      (seed),
		.cmd       (cmd),
		.status    (status),
		.key       (key),
		.key_index (key_index),
		.last      (last)
	);

endmodule
